/* rtl/core/snf_pkg.sv */
`timescale 1ns / 1ps
package snf_pkg;
    localparam int FLASH_BYTES = 65536;
    localparam int SECTOR_BYTES = 4096;
    localparam int PAGE_BYTES = 256;
    localparam int AW = $clog2(FLASH_BYTES);
    localparam int SW = $clog2(SECTOR_BYTES);
    localparam int PW = $clog2(PAGE_BYTES);

    localparam logic [7:0] OP_NONE = 8'h00;
    localparam logic [7:0] OP_WREN = 8'h06;
    localparam logic [7:0] OP_WRDI = 8'h04;
    localparam logic [7:0] OP_RDSR = 8'h05;
    localparam logic [7:0] OP_READ = 8'h03;
    localparam logic [7:0] OP_PP = 8'h02;
    localparam logic [7:0] OP_SE = 8'h20;
    localparam logic [7:0] OP_CE = 8'hC7;
    localparam logic [7:0] OP_PD = 8'hB9;
    localparam logic [7:0] OP_RPD = 8'hAB;
    localparam logic [7:0] OP_ID = 8'h90;

    localparam logic [1:0] MODE_BYTE = 2'd0;
    localparam logic [1:0] MODE_END = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    localparam logic [1:0] REG_BUSY_TICKS = 2'd0;
    localparam logic [1:0] REG_MFR_ID = 2'd1;
    localparam logic [1:0] REG_DEV_ID = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] mosi_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] miso_byte;
        logic       busy_now;
    } t_out;
endpackage

/* rtl/core/snf_ram.sv */
`timescale 1ns / 1ps
module snf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/core/spi_nor_flash_device.sv */
`timescale 1ns / 1ps
// spi nor flash device: takes one spi transfer per item, returns one result
// input channel i_in_*: mode 0 is a byte inside a chip-select frame, mode 1
// the chip-select rise, mode 2 one busy time tick
// output channel o_out_*: miso byte for that item and the busy bit after it
// a plain item goes through accept and result transfer; a read or program
// data byte through accept, storage read, write back, result transfer, as
// the storage ram has one read and one write port; program data bytes
// read-modify-write it; a new item is taken once the result register is free
// sector and chip erase at chip-select rise sweep the ram one byte a cycle
// (SECTOR_BYTES or FLASH_BYTES bytes) before the result is shown
// after reset a clearing pass writes 0xFF to all FLASH_BYTES bytes, during
// which no item is taken; configuration writes are taken at any time
// when the receiver stalls, the result holds and no further item is taken
// reset is synchronous, active low, and restores the register defaults
module spi_nor_flash_device (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  snf_pkg::t_in     i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output snf_pkg::t_out    o_out_data,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data
);
    import snf_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_WRITE, S_ERASE, S_DONE
    } t_state;

    t_state r_state;
    logic [15:0] r_busy_ticks;
    logic [7:0] r_mfr_id, r_dev_id;
    logic [7:0] r_opcode;
    logic [2:0] r_cnt;
    logic [23:0] r_addr;
    logic r_wel, r_pd, r_idt;
    logic [15:0] r_busy;
    logic [AW-1:0] r_ptr, r_end;
    logic [7:0] r_b;
    logic [7:0] r_miso;
    logic [7:0] n_miso;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0] ram_wdata, ram_rdata;

    snf_ram #(.WIDTH(8), .DEPTH(FLASH_BYTES)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    wire is_data = (r_cnt == 3'd4);
    wire do_pp = (r_opcode == OP_PP) && r_wel && is_data;
    wire go_read = (i_in_data.mode == MODE_BYTE) && is_data
                   && (r_opcode == OP_READ || r_opcode == OP_PP);
    wire go_erase = (i_in_data.mode == MODE_END) && (r_cnt != 3'd0) && r_wel
                    && ((r_opcode == OP_SE && is_data) || r_opcode == OP_CE);

    always_comb begin
        n_miso = 8'hFF;
        if (i_in_data.mode == MODE_BYTE && r_cnt != 3'd0) begin
            if (r_opcode == OP_RDSR) begin
                n_miso = {6'd0, r_wel, r_busy != 16'd0};
            end else if (is_data) begin
                case (r_opcode)
                    OP_ID: n_miso = r_idt ? r_dev_id : r_mfr_id;
                    OP_RPD: n_miso = r_dev_id;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        ram_raddr = r_addr[AW-1:0];
        ram_we = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = 8'hFF;
        case (r_state)
            S_CLEAR, S_ERASE: ram_we = 1'b1;
            S_WRITE: begin
                ram_we = do_pp;
                ram_waddr = r_addr[AW-1:0];
                ram_wdata = ram_rdata & r_b;
            end
            default: ;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign o_out_data = '{miso_byte: r_miso, busy_now: (r_busy != 16'd0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_ticks <= 16'd16;
            r_mfr_id <= 8'hEF;
            r_dev_id <= 8'h16;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BUSY_TICKS: r_busy_ticks <= i_cfg_data;
                REG_MFR_ID: r_mfr_id <= i_cfg_data[7:0];
                REG_DEV_ID: r_dev_id <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ptr <= '0;
            r_end <= '1;
            r_opcode <= OP_NONE;
            r_cnt <= '0;
            r_addr <= '0;
            r_wel <= 1'b0;
            r_pd <= 1'b0;
            r_idt <= 1'b0;
            r_busy <= '0;
        end else begin
            case (r_state)
                S_CLEAR, S_ERASE: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr == r_end) begin
                        r_state <= (r_state == S_CLEAR) ? S_IDLE : S_DONE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_miso <= n_miso;
                        r_b <= i_in_data.mosi_byte;
                        r_state <= go_read ? S_READ : (go_erase ? S_ERASE : S_DONE);
                        case (i_in_data.mode)
                            MODE_BYTE: begin
                                if (r_cnt != 3'd4) r_cnt <= r_cnt + 1'b1;
                                if (r_cnt == 3'd0) begin
                                    if ((r_busy != 0 && i_in_data.mosi_byte != OP_RDSR)
                                        || (r_pd && i_in_data.mosi_byte != OP_RPD)) begin
                                        r_opcode <= OP_NONE;
                                    end else begin
                                        r_opcode <= i_in_data.mosi_byte;
                                    end
                                    r_addr <= '0;
                                end else if (r_opcode != OP_RDSR && r_cnt <= 3'd3) begin
                                    r_addr <= {r_addr[15:0], i_in_data.mosi_byte};
                                    if (r_cnt == 3'd3) r_idt <= i_in_data.mosi_byte[0];
                                end else if (r_opcode == OP_ID) begin
                                    r_idt <= ~r_idt;
                                end
                            end
                            MODE_END: begin
                                r_cnt <= '0;
                                r_opcode <= OP_NONE;
                                if (r_cnt != 3'd0) begin
                                    case (r_opcode)
                                        OP_WREN: r_wel <= 1'b1;
                                        OP_WRDI: r_wel <= 1'b0;
                                        OP_PD: r_pd <= 1'b1;
                                        OP_RPD: r_pd <= 1'b0;
                                        OP_PP: begin
                                            if (r_cnt == 3'd4 && r_wel) begin
                                                r_busy <= r_busy_ticks;
                                                r_wel <= 1'b0;
                                            end
                                        end
                                        OP_SE: begin
                                            if (r_cnt == 3'd4 && r_wel) begin
                                                r_busy <= r_busy_ticks;
                                                r_wel <= 1'b0;
                                                r_ptr <= {r_addr[AW-1:SW], {SW{1'b0}}};
                                                r_end <= {r_addr[AW-1:SW], {SW{1'b1}}};
                                            end
                                        end
                                        OP_CE: begin
                                            if (r_wel) begin
                                                r_busy <= r_busy_ticks;
                                                r_wel <= 1'b0;
                                                r_ptr <= '0;
                                                r_end <= '1;
                                            end
                                        end
                                        default: ;
                                    endcase
                                end
                            end
                            MODE_TICK: if (r_busy != 0) r_busy <= r_busy - 1'b1;
                            default: ;
                        endcase
                    end
                end
                S_READ: r_state <= S_WRITE;
                S_WRITE: begin
                    r_state <= S_DONE;
                    if (r_opcode == OP_READ) begin
                        r_miso <= ram_rdata;
                        r_addr <= r_addr + 1'b1;
                    end else if (do_pp) begin
                        r_addr[PW-1:0] <= r_addr[PW-1:0] + 1'b1;
                    end
                end
                S_DONE: if (!i_out_stall) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/core/snf_checker.sv */
`timescale 1ns / 1ps
module snf_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input snf_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input snf_pkg::t_out o_out_data
);
    import snf_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed under stall");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while result pending");

    a_take_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("no work after transfer");

    a_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.mode == MODE_TICK
        |=> o_out_valid && o_out_data.miso_byte == 8'hFF)
        else $error("tick result wrong");
endmodule

bind spi_nor_flash_device snf_checker u_snf_checker (.*);
